// ===== design/assert_macros.svh =====
// assertion macros of the leg contact event detector, included by lced_leg
// no dependencies; every macro checks on the rising clock edge with reset masked
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// boolean that must hold at every clock edge outside reset
`define LCED_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

// antecedent in this cycle requires consequent in the same cycle
`define LCED_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// antecedent in this cycle requires consequent in the next cycle
`define LCED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== design/lced_pkg.sv =====
// types and constants of the leg contact event detector
// no dependencies; used by lced_in_stage, lced_leg and the top level
package lced_pkg;

   // fixed field widths of the request and response words, and the tick counter width
   localparam int TIME_FIELD_W = 32;
   localparam int OUT_LEGS     = 4;
   localparam int TICKS_W      = 8;

   // configuration port
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_SUSTAIN_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_SPLICE_ENABLE     = 1'b1;

   localparam logic [TICKS_W-1:0] THRESHOLD_RESET    = 8'd5;
   localparam logic               SPLICE_ENABLE_RESET = 1'b1;
   localparam logic [TICKS_W-1:0] TICKS_MAX          = 8'hFF;

   // one control tick
   typedef struct packed {
      logic [TIME_FIELD_W-1:0] time_us;
      logic [OUT_LEGS-1:0]     measured_contact;
      logic [OUT_LEGS-1:0]     scheduled_contact;
      logic [OUT_LEGS-1:0]     in_window;
   } req_word_type;

   // one result per tick
   typedef struct packed {
      logic [OUT_LEGS-1:0]     first_contact_mask;
      logic [OUT_LEGS-1:0]     splice_mask;
      logic [TIME_FIELD_W-1:0] event_time_leg0;
      logic [TIME_FIELD_W-1:0] event_time_leg1;
      logic [TIME_FIELD_W-1:0] event_time_leg2;
      logic [TIME_FIELD_W-1:0] event_time_leg3;
   } rsp_word_type;

   // per-leg bits of one tick
   typedef struct packed {
      logic meas;
      logic sched;
      logic win;
   } leg_bits_type;

   // per-leg event flags of one tick
   typedef struct packed {
      logic first;
      logic splice;
   } leg_flags_type;

   // settings shared by every leg
   typedef struct packed {
      logic [TICKS_W-1:0] threshold;
      logic               splice_en;
   } leg_cfg_type;

endpackage

// ===== design/lced_in_stage.sv =====
// input register of the leg contact event detector
// depends on lced_pkg for the request word type
module lced_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lced_pkg::req_word_type req_word,
   input  logic                 advance,
   output logic                 held_valid,
   output lced_pkg::req_word_type held_word
);
   import lced_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         take;

   // free when empty or when the held word moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= req_word;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule

// ===== design/lced_leg.sv =====
// per-leg contact state and event logic
// depends on lced_pkg and assert_macros.svh
`include "assert_macros.svh"

module lced_leg #(
   parameter int CAP_W = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  lced_pkg::leg_cfg_type     cfg,
   input  lced_pkg::leg_bits_type    bits,
   input  logic [CAP_W-1:0]          time_now,
   output lced_pkg::leg_flags_type   flags,
   output logic [CAP_W-1:0]          splice_time
);
   import lced_pkg::*;

   logic               prev_ff, prev_in;
   logic               logged_ff, logged_in;
   logic               req_ff, req_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;

   logic               liftoff;
   logic               robust;
   logic               logged_base;
   logic               req_base;
   logic [TICKS_W-1:0] ticks_base;
   logic [CAP_W-1:0]   cap_base;
   logic               first;
   logic               splice;

   // scheduled stance-to-swing edge clears the window state
   assign liftoff     = prev_ff && !bits.sched;
   assign logged_base = liftoff ? 1'b0 : logged_ff;
   assign req_base    = liftoff ? 1'b0 : req_ff;
   assign ticks_base  = liftoff ? '0 : ticks_ff;
   assign cap_base    = liftoff ? '0 : cap_ff;

   // measured contact during scheduled swing inside the window
   assign robust = bits.win && bits.meas && !bits.sched;

   // saturating run counter, time of the first tick of the run
   always_comb begin
      if (!robust) begin
         ticks_in = '0;
      end else if (ticks_base == TICKS_MAX) begin
         ticks_in = TICKS_MAX;
      end else begin
         ticks_in = ticks_base + 1'b1;
      end
   end

   assign cap_in = (robust && (ticks_base == '0)) ? time_now : cap_base;

   // one-shot flags per window
   assign first     = robust && !logged_base;
   assign logged_in = logged_base || robust;
   assign splice    = robust && (ticks_in >= cfg.threshold) && !req_base && cfg.splice_en;
   assign req_in    = req_base || splice;
   assign prev_in   = bits.sched;

   // state update once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 1'b0;
         logged_ff <= 1'b0;
         req_ff    <= 1'b0;
         ticks_ff  <= '0;
         cap_ff    <= '0;
      end else if (advance) begin
         prev_ff   <= prev_in;
         logged_ff <= logged_in;
         req_ff    <= req_in;
         ticks_ff  <= ticks_in;
         cap_ff    <= cap_in;
      end
   end

   assign flags.first  = first;
   assign flags.splice = splice;
   assign splice_time  = splice ? cap_in : '0;

   // a running count always means the window already logged its first contact
   `LCED_ASSERT_ALWAYS(a_ticks_logged, clock, reset, (ticks_ff == '0) || logged_ff)
   // a splice only comes out of a live run
   `LCED_ASSERT_SAME(a_splice_run, clock, reset, advance && splice, ticks_in != '0)
   // an issued splice latches until the next liftoff
   `LCED_ASSERT_NEXT(a_splice_latch, clock, reset, advance && splice, req_ff)

endmodule

// ===== design/leg_contact_event_detector.sv =====
// Leg contact event detector, top level.
// A word taken into the input register moves on to the result register when that is free.
// Throughput: one word per cycle while the result register is free or being taken, through
// the per-leg state update between the input register and the result register.
// Reset (synchronous, active high) clears all leg state, empties both registers
// and loads the threshold with 5 and splice enable with 1.
module leg_contact_event_detector #(
   parameter int NUM_LEGS   = 4,
   parameter int TIME_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lced_pkg::req_word_type                req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lced_pkg::rsp_word_type                rsp_word,
   input  logic                                  csr_write_enable,
   input  logic [lced_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lced_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import lced_pkg::*;

   localparam int ACT_LEGS = (NUM_LEGS < OUT_LEGS) ? NUM_LEGS : OUT_LEGS;
   localparam int CAP_W    = (TIME_WIDTH < TIME_FIELD_W) ? TIME_WIDTH : TIME_FIELD_W;

   logic [TICKS_W-1:0] thr_ff, thr_in;
   logic               en_ff, en_in;
   leg_cfg_type        cfg;

   logic               held_valid;
   req_word_type       held_word;
   logic               advance;

   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff, rsp_word_in;
   logic [OUT_LEGS-1:0]          first_mask;
   logic [OUT_LEGS-1:0]          splice_mask;
   logic [OUT_LEGS-1:0][TIME_FIELD_W-1:0] ev_time;

   // configuration registers
   always_comb begin
      thr_in = thr_ff;
      en_in  = en_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IDX_SUSTAIN_THRESHOLD: thr_in = csr_write_data;
            CSR_IDX_SPLICE_ENABLE:     en_in  = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         en_ff  <= SPLICE_ENABLE_RESET;
      end else begin
         thr_ff <= thr_in;
         en_ff  <= en_in;
      end
   end

   assign cfg.threshold = thr_ff;
   assign cfg.splice_en = en_ff;

   // the held word moves into the result register when that is free
   assign advance = held_valid && (!rsp_valid_ff || rsp_ready);

   lced_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .advance    (advance),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   // one cell per leg that has input bits
   for (genvar i = 0; i < OUT_LEGS; i++) begin : g_leg
      if (i < ACT_LEGS) begin : g_on
         leg_bits_type     bits;
         leg_flags_type    flags;
         logic [CAP_W-1:0] ev;

         assign bits.meas  = held_word.measured_contact[i];
         assign bits.sched = held_word.scheduled_contact[i];
         assign bits.win   = held_word.in_window[i];

         lced_leg #(
            .CAP_W (CAP_W)
         ) u_leg (
            .clock       (clock),
            .reset       (reset),
            .advance     (advance),
            .cfg         (cfg),
            .bits        (bits),
            .time_now    (held_word.time_us[CAP_W-1:0]),
            .flags       (flags),
            .splice_time (ev)
         );

         assign first_mask[i]  = flags.first;
         assign splice_mask[i] = flags.splice;
         assign ev_time[i]     = TIME_FIELD_W'(ev);
      end else begin : g_off
         assign first_mask[i]  = 1'b0;
         assign splice_mask[i] = 1'b0;
         assign ev_time[i]     = '0;
      end
   end

   // result word assembly
   always_comb begin
      rsp_word_in.first_contact_mask = first_mask;
      rsp_word_in.splice_mask        = splice_mask;
      rsp_word_in.event_time_leg0    = ev_time[0];
      rsp_word_in.event_time_leg1    = ev_time[1];
      rsp_word_in.event_time_leg2    = ev_time[2];
      rsp_word_in.event_time_leg3    = ev_time[3];
   end

   // result register
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
